[rtl/core/csvt_pkg.sv]
// shared types and constants for the csv field tokenizer
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;

  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam int unsigned MAX_FIELDS_DFLT = 255;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_QUOTE    = 3'd1;
  localparam logic [2:0] ERR_AFTER_Q  = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_COUNT    = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       row_end;
    logic [7:0] row_field_count;
    logic       done_res;
    logic [2:0] error_code;
  } res_t;

endpackage

[rtl/core/csvt_in_stage.sv]
// input register stage of the csv field tokenizer
module csvt_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic                advance,
  output logic                item_vld,
  output csvt_pkg::item_t     item
);
  import csvt_pkg::*;

  logic  vld_r;
  item_t item_r;

  assign in_tready = !vld_r || advance;
  assign item_vld  = vld_r;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      item_r.data <= in_tdata;
      item_r.eod  <= in_tlast;
    end
  end

endmodule

[rtl/core/csvt_parse.sv]
// parser state and combinational next-state and result logic
module csvt_parse #(
  parameter int unsigned MAX_FIELDS = csvt_pkg::MAX_FIELDS_DFLT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  logic            advance,
  input  csvt_pkg::item_t item,
  output csvt_pkg::res_t  res
);
  import csvt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FIELDS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FIELDS);

  typedef enum logic [1:0] {
    PH_START,
    PH_PLAIN,
    PH_QUOTED,
    PH_QMARK
  } phase_t;

  logic [7:0]    sep_r;
  phase_t        ph_r, ph_nxt;
  logic          cr_pend_r, cr_pend_nxt;
  logic          at_start_r, at_start_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic          first_seen_r, first_seen_nxt;
  logic          halted_r, halted_nxt;

  logic          is_end;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] row_cnt;
  logic [31:0]   row_cnt32;
  logic          mismatch;

  assign is_end  = item.eod || (item.data == CH_NUL);
  assign cnt_inc = (cnt_r < CNT_MAX) ? cnt_r + CW'(1) : cnt_r;

  // row closes with the new field counted unless the phase says the field is already closed
  always_comb begin
    if (is_end && !(ph_r == PH_PLAIN || ph_r == PH_QMARK || at_start_r)) begin
      row_cnt = cnt_r;
    end else begin
      row_cnt = cnt_inc;
    end
  end

  assign row_cnt32 = 32'(row_cnt);
  assign mismatch  = first_seen_r && (row_cnt != first_r);

  always_comb begin
    res            = '0;
    ph_nxt         = ph_r;
    cr_pend_nxt    = cr_pend_r;
    at_start_nxt   = at_start_r;
    cnt_nxt        = cnt_r;
    first_nxt      = first_r;
    first_seen_nxt = first_seen_r;
    halted_nxt     = halted_r;

    if (is_end) begin
      if (!halted_r) begin
        if (ph_r == PH_QUOTED) begin
          res.error_code = ERR_UNCLOSED;
        end else if (ph_r == PH_PLAIN || ph_r == PH_QMARK || at_start_r || cnt_r != '0) begin
          res.field_end       = (ph_r == PH_PLAIN || ph_r == PH_QMARK || at_start_r);
          res.row_end         = 1'b1;
          res.row_field_count = (row_cnt32 > 32'd255) ? 8'hFF : row_cnt32[7:0];
          if (mismatch) begin
            res.error_code = ERR_COUNT;
          end
        end
      end
      res.done_res   = 1'b1;
      ph_nxt         = PH_START;
      cr_pend_nxt    = 1'b0;
      at_start_nxt   = 1'b1;
      cnt_nxt        = '0;
      first_nxt      = '0;
      first_seen_nxt = 1'b0;
      halted_nxt     = 1'b0;
    end else if (halted_r) begin
      // halted: all-zero results until end of data
    end else if (ph_r == PH_START && cr_pend_r && item.data == CH_LF) begin
      cr_pend_nxt = 1'b0;
    end else begin
      cr_pend_nxt  = 1'b0;
      at_start_nxt = 1'b0;
      if (ph_r == PH_QUOTED) begin
        if (item.data == CH_QUOTE) begin
          ph_nxt = PH_QMARK;
        end else begin
          res.out_char   = item.data;
          res.char_valid = 1'b1;
        end
      end else if (item.data == CH_QUOTE) begin
        priority if (ph_r == PH_PLAIN) begin
          res.error_code = ERR_QUOTE;
          halted_nxt     = 1'b1;
        end else if (ph_r == PH_QMARK) begin
          // doubled quote gives one quote of content
          res.out_char   = CH_QUOTE;
          res.char_valid = 1'b1;
          ph_nxt         = PH_QUOTED;
        end else begin
          ph_nxt = PH_QUOTED;
        end
      end else if (item.data == sep_r) begin
        res.field_end = 1'b1;
        cnt_nxt       = cnt_inc;
        ph_nxt        = PH_START;
      end else if (item.data == CH_CR || item.data == CH_LF) begin
        res.field_end       = 1'b1;
        res.row_end         = 1'b1;
        res.row_field_count = (row_cnt32 > 32'd255) ? 8'hFF : row_cnt32[7:0];
        if (!first_seen_r) begin
          first_seen_nxt = 1'b1;
          first_nxt      = row_cnt;
        end else if (mismatch) begin
          res.error_code = ERR_COUNT;
          halted_nxt     = 1'b1;
        end
        cnt_nxt     = '0;
        ph_nxt      = PH_START;
        cr_pend_nxt = (item.data == CH_CR);
      end else if (ph_r == PH_QMARK) begin
        res.error_code = ERR_AFTER_Q;
        halted_nxt     = 1'b1;
      end else begin
        res.out_char   = item.data;
        res.char_valid = 1'b1;
        ph_nxt         = PH_PLAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r        <= SEP_RESET;
      ph_r         <= PH_START;
      cr_pend_r    <= 1'b0;
      at_start_r   <= 1'b1;
      cnt_r        <= '0;
      first_r      <= '0;
      first_seen_r <= 1'b0;
      halted_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      if (advance) begin
        ph_r         <= ph_nxt;
        cr_pend_r    <= cr_pend_nxt;
        at_start_r   <= at_start_nxt;
        cnt_r        <= cnt_nxt;
        first_r      <= first_nxt;
        first_seen_r <= first_seen_nxt;
        halted_r     <= halted_nxt;
      end
    end
  end

endmodule

[rtl/core/csvt_out_stage.sv]
// result register stage of the csv field tokenizer
module csvt_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  csvt_pkg::res_t res,
  output logic           advance,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [23:0]    out_tdata,
  output logic           out_tlast,
  output logic [0:0]     out_tuser
);
  import csvt_pkg::*;

  logic vld_r;
  res_t res_r;

  assign advance    = item_vld && (!vld_r || out_tready);
  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, res_r.error_code, res_r.done_res, res_r.row_field_count,
                       res_r.field_end, res_r.out_char};
  assign out_tlast  = res_r.row_end;
  assign out_tuser  = res_r.char_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
    if (advance) begin
      res_r <= res;
    end
  end

endmodule

[rtl/core/csv_field_tokenizer_core.sv]
// Streaming CSV tokenizer: one result item out per byte item in, at a rate of one item per cycle
// while out_tready stays high (input register, then the parser's combinational state update
// into the result register). The parser state updates on each accepted item, so bytes of the
// same stream flow back to back. in_tlast marks end of data (a zero byte does the same); that
// item returns done_res and rearms the parser. The field separator survives rearming and is to
// be written via cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
module csv_field_tokenizer_core #(
  parameter int unsigned MAX_FIELDS = csvt_pkg::MAX_FIELDS_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // field_separator
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] in_byte
  input  logic        in_tlast,      // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [7:0] out_char, [8] field_end, [16:9] row_field_count,
                                     // [17] done_res, [20:18] error_code, [23:21] zero
  output logic        out_tlast,     // row_end
  output logic [0:0]  out_tuser      // [0] char_valid
);
  import csvt_pkg::*;

  logic  advance;
  logic  item_vld;
  item_t item;
  res_t  res;

  csvt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  csvt_parse #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .res         (res)
  );

  csvt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (item_vld),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/csvt_checker.sv]
// port-level checks for the csv field tokenizer, bound to the top level
module csvt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);
  import csvt_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result item changed");

  // an error or end of data never carries a content byte
  a_err_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[20:18] != ERR_NONE || out_tdata[17]) |-> !out_tuser[0])
    else $error("content byte alongside error or done");

  // a row end reports no error or only a count mismatch
  a_row_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[20:18] == ERR_NONE || out_tdata[20:18] == ERR_COUNT)
    else $error("bad error code on row end");

  a_count_only_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[16:9] == 8'd0 && out_tdata[20:18] != ERR_COUNT)
    else $error("row count or mismatch without row end");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[test/tb_csv_field_tokenizer_core.sv]
`timescale 1ns / 1ps
// testbench for the csv field tokenizer core: csv text streams checked against a scoreboard
module tb_csv_field_tokenizer_core;
  import csvt_pkg::*;

  localparam int FIELD_CAP   = MAX_FIELDS_DFLT;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [7:0] SEPARATORS [8] = '{8'd44, 8'd1, 8'd255, 8'd59, 8'd13, 8'd10, 8'd34,
                                            8'd9};
  localparam logic [2:0] FLAW_KINDS [4] = '{ERR_QUOTE, ERR_AFTER_Q, ERR_UNCLOSED, ERR_COUNT};

  typedef enum logic [1:0] {
    SCAN_FIELD_START,
    SCAN_UNQUOTED,
    SCAN_IN_QUOTES,
    SCAN_QUOTE_SEEN
  } scan_t;

  class token_scoreboard;
    logic [7:0] separator;
    scan_t      scan;
    bit         cr_seen;
    bit         data_start;
    bit         first_row_done;
    bit         halted;
    int         row_fields;
    int         first_row_fields;
    res_t       tok;
    res_t       pending_tokens[$];
    int         mismatches;
    int         bytes_taken;
    int         tokens_checked;
    int         data_sets;
    int         reports[5];

    function new();
      separator = SEP_RESET;
      rearm();
      mismatches = 0;
      bytes_taken = 0;
      tokens_checked = 0;
      data_sets = 0;
      foreach (reports[i]) reports[i] = 0;
    endfunction

    function void rearm();
      scan = SCAN_FIELD_START;
      cr_seen = 1'b0;
      data_start = 1'b1;
      row_fields = 0;
      first_row_fields = 0;
      first_row_done = 1'b0;
      halted = 1'b0;
    endfunction

    function void emit(logic [7:0] b);
      tok.out_char = b;
      tok.char_valid = 1'b1;
    endfunction

    function void fail_with(logic [2:0] code);
      tok.error_code = code;
      halted = 1'b1;
    endfunction

    function void bump_field();
      tok.field_end = 1'b1;
      if (row_fields < FIELD_CAP) row_fields++;
    endfunction

    function void close_row();
      tok.row_end = 1'b1;
      tok.row_field_count = (row_fields > 255) ? 8'd255 : row_fields[7:0];
      if (!first_row_done) begin
        first_row_done = 1'b1;
        first_row_fields = row_fields;
      end else if (row_fields != first_row_fields) begin
        fail_with(ERR_COUNT);
      end
      row_fields = 0;
      scan = SCAN_FIELD_START;
    endfunction

    function void tokenize_byte(logic [7:0] b, logic last);
      tok = '0;
      if (last || b == CH_NUL) begin
        if (!halted) begin
          if (scan == SCAN_IN_QUOTES) begin
            tok.error_code = ERR_UNCLOSED;
          end else if (scan != SCAN_FIELD_START || data_start) begin
            bump_field();
            close_row();
          end else if (row_fields > 0) begin
            close_row();
          end
        end
        tok.done_res = 1'b1;
        rearm();
        return;
      end
      if (halted) return;
      // lf right after a cr row end is swallowed
      if (scan == SCAN_FIELD_START && cr_seen && b == CH_LF) begin
        cr_seen = 1'b0;
        return;
      end
      cr_seen = 1'b0;
      data_start = 1'b0;
      if (scan == SCAN_IN_QUOTES) begin
        if (b == CH_QUOTE) scan = SCAN_QUOTE_SEEN;
        else emit(b);
        return;
      end
      if (b == CH_QUOTE) begin
        if (scan == SCAN_UNQUOTED) begin
          fail_with(ERR_QUOTE);
        end else begin
          if (scan == SCAN_QUOTE_SEEN) emit(CH_QUOTE);
          scan = SCAN_IN_QUOTES;
        end
        return;
      end
      if (b == separator) begin
        bump_field();
        scan = SCAN_FIELD_START;
        return;
      end
      if (b == CH_CR || b == CH_LF) begin
        bump_field();
        close_row();
        cr_seen = (b == CH_CR);
        return;
      end
      if (scan == SCAN_QUOTE_SEEN) begin
        fail_with(ERR_AFTER_Q);
        return;
      end
      emit(b);
      scan = SCAN_UNQUOTED;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      tokenize_byte(b, last);
      pending_tokens = {pending_tokens, tok};
      bytes_taken++;
      if (tok.error_code != ERR_NONE) reports[tok.error_code]++;
      if (tok.done_res) data_sets++;
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_token(logic [23:0] data, logic last, logic user);
      res_t want;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $error("result item with no byte item waiting");
        return;
      end
      want = pending_tokens.pop_front();
      tokens_checked++;
      compare("out_char", want.out_char, data[7:0]);
      compare("char_valid", want.char_valid, user);
      compare("field_end", want.field_end, data[8]);
      compare("row_end", want.row_end, last);
      compare("row_field_count", want.row_field_count, data[16:9]);
      compare("done_res", want.done_res, data[17]);
      compare("error_code", want.error_code, data[20:18]);
      compare("tdata padding", 0, data[23:21]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  wire         in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [23:0] out_tdata;
  wire         out_tlast;
  wire  [0:0]  out_tuser;

  token_scoreboard sb;
  bit              no_gaps = 1'b0;
  int              idle_cycles = 0;
  logic [8:0]      text_q[$];   // {end_of_data, byte}

  csv_field_tokenizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 27);
  end

  // inputs are noted before results so a same-edge result still finds its expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid === 1'b1 && in_tready === 1'b1) sb.note_byte(in_tdata, in_tlast);
      if (out_tvalid === 1'b1 && out_tready) sb.check_token(out_tdata, out_tlast, out_tuser[0]);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_entry(logic [8:0] e);
    text_q = {text_q, e};
  endfunction

  function automatic void put(logic [7:0] b);
    queue_entry({1'b0, b});
  endfunction

  function automatic void put_str(string s);
    foreach (s[i]) put(s[i]);
  endfunction

  // end of data either by the end marker with a random byte or by a zero byte
  function automatic void put_end();
    if ($urandom_range(1)) queue_entry({1'b1, 8'($urandom)});
    else put(CH_NUL);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(9) < 7) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
    end while (b == CH_QUOTE || b == CH_CR || b == CH_LF || b == sb.separator);
    return b;
  endfunction

  function automatic void put_quoted();
    logic [7:0] b;
    case ($urandom_range(9))
      0: b = sb.separator;
      1: b = CH_CR;
      2: b = CH_LF;
      3: b = CH_QUOTE;
      default: b = 8'($urandom_range(1, 255));
    endcase
    put(b);
    if (b == CH_QUOTE) put(b);
  endfunction

  function automatic void put_field(logic [2:0] flaw);
    int n;
    int style;
    n = $urandom_range(5);
    style = $urandom_range(2);
    if (flaw == ERR_QUOTE) begin
      repeat ($urandom_range(1, 3)) put(plain_byte());
      put(CH_QUOTE);
      put(plain_byte());
      return;
    end
    if (flaw == ERR_AFTER_Q) style = 2;
    if (style == 1) begin
      repeat (n + 1) put(plain_byte());
    end else if (style == 2) begin
      put(CH_QUOTE);
      repeat (n) put_quoted();
      put(CH_QUOTE);
      if (flaw == ERR_AFTER_Q) put(plain_byte());
    end
  endfunction

  function automatic void put_row_end();
    case ($urandom_range(2))
      0: begin
        put(CH_CR);
        put(CH_LF);
      end
      1: put(CH_LF);
      default: put(CH_CR);
    endcase
  endfunction

  function automatic void put_table(bit flawed);
    int rows;
    int cols;
    int width;
    int bad_row;
    int bad_col;
    logic [2:0] flaw;
    rows = $urandom_range(1, 4);
    cols = $urandom_range(1, 5);
    flaw = flawed ? FLAW_KINDS[$urandom_range(3)] : ERR_NONE;
    if (flaw == ERR_COUNT && rows == 1) rows = 2;
    bad_row = (flaw == ERR_COUNT) ? $urandom_range(1, rows - 1) : $urandom_range(rows - 1);
    bad_col = $urandom_range(cols - 1);
    for (int r = 0; r < rows; r++) begin
      width = cols;
      if (flaw == ERR_COUNT && r == bad_row)
        width = (cols > 1 && $urandom_range(1)) ? cols - 1 : cols + 1;
      for (int c = 0; c < width; c++) begin
        if (r == bad_row && c == bad_col && (flaw == ERR_QUOTE || flaw == ERR_AFTER_Q))
          put_field(flaw);
        else
          put_field(ERR_NONE);
        if (c < width - 1) put(sb.separator);
      end
      if (r < rows - 1 || $urandom_range(1)) put_row_end();
    end
    if (flaw == ERR_UNCLOSED) begin
      put(sb.separator);
      put(CH_QUOTE);
      repeat ($urandom_range(3)) put_quoted();
    end else if ($urandom_range(9) == 0) begin
      put(sb.separator);
    end
    put_end();
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(4, 20)) begin
      case ($urandom_range(11))
        0: put(CH_QUOTE);
        1: put(sb.separator);
        2: put(CH_CR);
        3: put(CH_LF);
        4: if ($urandom_range(4) == 0) put_end();
        default: put(8'($urandom_range(1, 255)));
      endcase
    end
    put_end();
  endfunction

  // one row past the field cap, then a short row that cannot match it
  function automatic void put_wide_rows();
    repeat (FIELD_CAP + 15) put(sb.separator);
    put(CH_LF);
    put(plain_byte());
    put(sb.separator);
    put(plain_byte());
    put(CH_LF);
    put_end();
  endfunction

  task automatic send_item(input logic [7:0] b, input logic last);
    while (!no_gaps && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    logic [8:0] e;
    while (text_q.size() > 0) begin
      e = text_q.pop_front();
      send_item(e[7:0], e[8]);
    end
  endtask

  task automatic write_separator(input logic [7:0] sep);
    in_tvalid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sep;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.separator = sep;
  endtask

  initial begin
    int sent;
    int pick;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = SEP_RESET;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset separator
    queue_entry({1'b1, 8'hFF});           // end at the very start
    put_str("\"a\"\"b\"");                // opening quote, doubled quote and closing quote
    put(CH_CR);
    put(CH_LF);
    put(CH_NUL);                          // end after a finished row
    put_str("x,");
    queue_entry({1'b1, 8'h00});           // trailing separator
    put_str("a\"b");
    queue_entry({1'b1, 8'h7E});           // quote in unquoted field, then halted
    put_str("\"\"z");
    put(CH_NUL);                          // text after closing quote
    put(CH_QUOTE);
    put(CH_NUL);                          // quote left open
    put_str("a");
    put(CH_LF);
    put_str("b,c");
    queue_entry({1'b1, 8'h80});           // count mismatch on the final row
    send_text();

    foreach (SEPARATORS[p]) begin
      write_separator(SEPARATORS[p]);
      no_gaps = (SEPARATORS[p] == 8'd59);
      if (no_gaps) begin
        put_wide_rows();
        send_text();
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 65) put_table(1'b0);
        else if (pick < 85) put_table(1'b1);
        else put_noise();
        sent += text_q.size();
        send_text();
      end
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("run covered %0d byte items in %0d data sets over %0d separator settings",
             sb.bytes_taken, sb.data_sets, $size(SEPARATORS) + 1);
    $display("%0d result items checked; errors flagged: quote %0d, after close %0d, %s %0d, %s %0d",
             sb.tokens_checked, sb.reports[ERR_QUOTE], sb.reports[ERR_AFTER_Q], "unclosed",
             sb.reports[ERR_UNCLOSED], "count", sb.reports[ERR_COUNT]);
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
